@@ hdl/dmpg_pkg.sv @@
package dmpg_pkg;

    // Field widths of the streamed items.
    localparam int VAL_W = 32;
    localparam int SUM_W = 40;

    // Configuration port.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    // Item kinds.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Saturation limits of the accumulators.
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic                    mode;
        logic signed [VAL_W-1:0] input_value;
        logic signed [VAL_W-1:0] grad_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] grad_sum;
        logic                    last_of_plane;
    } t_out_item;

endpackage

@@ hdl/dmpg_ram.sv @@
module dmpg_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 38
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/directional_max_pool_gradient.sv @@
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid/o_in_ready   i_in_data   (t_in_item)
// out       output     o_out_valid/i_out_ready o_out_data  (t_out_item)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A load transfer steps through column store read, compare and address
// multiply, accumulator read, then saturating add and write back.
// A drain transfer steps through accumulator read, then output and clear.
// After reset a clearing pass over MAX_WIDTH*MAX_HEIGHT addresses zeroes both
// stores; no input transfer is taken during it, configuration writes are.
// A drain result waits in the output register; the next item is accepted
// meanwhile, and a following drain stalls only if that register is full.
module directional_max_pool_gradient
    import dmpg_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (AW > 2 * CFG_W) ? AW : 2 * CFG_W;
    localparam int CMW   = VAL_W + RW;

    localparam logic [CFG_W-1:0] WCAP = CFG_W'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
    localparam logic [CFG_W-1:0] HCAP = CFG_W'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);
    localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_COL  = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_DRN  = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [CFG_W-1:0]        r_cfg_w, r_cfg_h;
    logic [RW-1:0]           r_load_row;
    logic [CW-1:0]           r_load_col;
    logic [AW-1:0]           r_drain_idx;
    logic [AW-1:0]           r_clr;
    logic signed [VAL_W-1:0] r_x, r_g;
    logic [RW-1:0]           r_row;
    logic [CW-1:0]           r_col;
    logic [IW-1:0]           r_prod;
    logic [AW-1:0]           r_addr;
    logic                    r_last;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic [CFG_W-1:0]        w_eff, h_eff;
    logic [IW-1:0]           total;
    logic                    accept, out_free;
    logic                    load_out;
    logic [RW-1:0]           eff_row;
    logic [CW-1:0]           eff_col;
    logic [IW-1:0]           col_inc, row_inc;
    logic [AW-1:0]           drain_eff;
    logic                    drain_last;
    logic [AW-1:0]           acc_sel;

    logic                    col_we, col_re;
    logic [CW-1:0]           col_waddr;
    logic [CMW-1:0]          col_wdata, col_rdata;
    logic signed [VAL_W-1:0] col_max;
    logic [RW-1:0]           col_max_row;
    logic                    replace;
    logic [RW-1:0]           new_row;

    logic                    acc_we, acc_re;
    logic [AW-1:0]           acc_waddr, acc_raddr;
    logic [SUM_W-1:0]        acc_wdata, acc_rdata;
    logic [SUM_W:0]          acc_sum;
    logic [SUM_W-1:0]        acc_sat;

    // Configuration registers; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_SIZE_RESET;
            r_cfg_h <= CFG_SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PLANE_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_PLANE_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective plane size: zero acts as one, large values clip to the maximum.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = CFG_W'(1);
        end else if (r_cfg_w > WCAP) begin
            w_eff = WCAP;
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = CFG_W'(1);
        end else if (r_cfg_h > HCAP) begin
            h_eff = HCAP;
        end else begin
            h_eff = r_cfg_h;
        end
        total = IW'(w_eff) * IW'(h_eff);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Load position, restarted when it lies outside the current plane.
    always_comb begin
        load_out = (IW'(r_load_row) >= IW'(h_eff)) || (IW'(r_load_col) >= IW'(w_eff));
        eff_row  = load_out ? '0 : r_load_row;
        eff_col  = load_out ? '0 : r_load_col;
        col_inc  = IW'(eff_col) + IW'(1);
        row_inc  = IW'(eff_row) + IW'(1);
    end

    // Drain position and end-of-plane flag.
    always_comb begin
        drain_eff  = (IW'(r_drain_idx) >= total) ? '0 : r_drain_idx;
        drain_last = (IW'(drain_eff) == total - IW'(1));
    end

    // Position counters advance when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_row  <= '0;
            r_load_col  <= '0;
            r_drain_idx <= '0;
        end else if (accept) begin
            if (i_in_data.mode == MODE_LOAD) begin
                if (col_inc >= IW'(w_eff)) begin
                    r_load_col <= '0;
                    r_load_row <= (row_inc >= IW'(h_eff)) ? '0 : row_inc[RW-1:0];
                end else begin
                    r_load_col <= col_inc[CW-1:0];
                    r_load_row <= eff_row;
                end
            end else begin
                r_drain_idx <= drain_last ? '0 : drain_eff + AW'(1);
            end
        end
    end

    // Column store: running maximum and its row for each column.
    assign col_re      = accept && (i_in_data.mode == MODE_LOAD);
    assign col_max     = col_rdata[CMW-1:RW];
    assign col_max_row = col_rdata[RW-1:0];
    assign replace     = (r_row == '0) || (r_x > col_max);
    assign new_row     = replace ? r_row : col_max_row;

    always_comb begin
        if (r_state == S_CLR) begin
            col_we    = (32'(r_clr) < 32'(MAX_WIDTH));
            col_waddr = r_clr[CW-1:0];
            col_wdata = '0;
        end else begin
            col_we    = (r_state == S_COL) && replace;
            col_waddr = r_col;
            col_wdata = {r_x, r_row};
        end
    end

    dmpg_ram #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW),
        .DATA_W (CMW)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_re    (col_re),
        .i_raddr (eff_col),
        .o_rdata (col_rdata)
    );

    // Accumulator address: fall back to row zero when the maximum row is off the plane.
    assign acc_sel = (r_prod >= total) ? AW'(r_col) : r_prod[AW-1:0];

    // Saturating add of the gradient onto the stored sum.
    always_comb begin
        acc_sum = {acc_rdata[SUM_W-1], acc_rdata}
                + {{(SUM_W + 1 - VAL_W){r_g[VAL_W-1]}}, r_g};
        if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
            acc_sat = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_sat = acc_sum[SUM_W-1:0];
        end
    end

    // Accumulator store ports.
    always_comb begin
        acc_re    = (accept && (i_in_data.mode == MODE_DRAIN)) || (r_state == S_ADDR);
        acc_raddr = (r_state == S_ADDR) ? acc_sel : drain_eff;
        acc_we    = (r_state == S_CLR) || (r_state == S_ACC) || (r_state == S_DRN);
        acc_waddr = (r_state == S_CLR) ? r_clr : r_addr;
        acc_wdata = (r_state == S_ACC) ? acc_sat : '0;
    end

    dmpg_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (SUM_W)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_re    (acc_re),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // Sequencer for clearing, load and drain steps.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == CLR_LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_data.mode == MODE_LOAD) ? S_COL : S_DRN;
                end
            end
            S_COL:  n_state = S_ADDR;
            S_ADDR: n_state = S_ACC;
            S_ACC:  n_state = S_IDLE;
            S_DRN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // Item payload and working registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_in_data.input_value;
            r_g    <= i_in_data.grad_value;
            r_row  <= eff_row;
            r_col  <= eff_col;
            r_last <= drain_last;
            r_addr <= drain_eff;
        end
        if (r_state == S_COL) begin
            r_prod <= IW'(new_row) * IW'(w_eff) + IW'(r_col);
        end
        if (r_state == S_ADDR) begin
            r_addr <= acc_sel;
        end
    end

    // Output register decouples the result from the next item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DRN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DRN) && out_free) begin
            r_out_data.grad_sum      <= acc_rdata;
            r_out_data.last_of_plane <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ sim/testbench.sv @@
module testbench;
    import dmpg_pkg::*;

    localparam int MAX_W        = 64;
    localparam int MAX_H        = 64;
    localparam int RESET_CYCLES = 11;
    // Long enough that any load still in flight reaches the store.
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT       = 2_000_000;
    // More than 256 full-scale gradients into one entry overflow 40 bits.
    localparam int SAT_LOADS    = 260;
    localparam int PHASE_ITEMS  = 90;
    localparam int MAX_JOB_AREA = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_TOP    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};
    localparam longint SUM_HI = $signed(SUM_MAX);
    localparam longint SUM_LO = $signed(SUM_MIN);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Shadow of the block: plane size, column maxima, gradient store, positions.
    logic [CFG_W-1:0]        width_reg  = CFG_SIZE_RESET;
    logic [CFG_W-1:0]        height_reg = CFG_SIZE_RESET;
    logic signed [VAL_W-1:0] col_peak     [MAX_W];
    int                      col_peak_row [MAX_W];
    longint                  grad_store   [MAX_W*MAX_H];
    int                      load_row  = 0;
    int                      load_col  = 0;
    int                      drain_idx = 0;

    t_out_item expected_sums [$];
    int        failures       = 0;
    int        items_sent     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles    = 0;

    directional_max_pool_gradient #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #TIMEOUT;
        $display("** directional_max_pool_gradient: FAILED **");
        $finish;
    end

    // A size of zero means one, anything above the maximum means the maximum.
    function automatic int eff_size(input logic [CFG_W-1:0] value, input int limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return int'(value);
    endfunction

    // Advances the shadow by one accepted item; a drain queues its expected result.
    function automatic void track_item(input t_in_item item);
        int        w;
        int        h;
        int        total;
        int        idx;
        longint    acc_sum;
        t_out_item want;
        w     = eff_size(width_reg, MAX_W);
        h     = eff_size(height_reg, MAX_H);
        total = w * h;
        if (item.mode == MODE_LOAD) begin
            if (load_row >= h || load_col >= w) begin
                load_row = 0;
                load_col = 0;
            end
            // Row 0 always takes the column; later rows only when strictly greater.
            if (load_row == 0 || item.input_value > col_peak[load_col]) begin
                col_peak[load_col]     = item.input_value;
                col_peak_row[load_col] = load_row;
            end
            idx = col_peak_row[load_col] * w + load_col;
            if (idx >= total) idx = load_col;
            acc_sum = grad_store[idx] + longint'(item.grad_value);
            if (acc_sum > SUM_HI) acc_sum = SUM_HI;
            if (acc_sum < SUM_LO) acc_sum = SUM_LO;
            grad_store[idx] = acc_sum;
            load_col++;
            if (load_col >= w) begin
                load_col = 0;
                load_row++;
                if (load_row >= h) load_row = 0;
            end
        end else begin
            if (drain_idx >= total) drain_idx = 0;
            want.grad_sum      = grad_store[drain_idx][SUM_W-1:0];
            want.last_of_plane = (drain_idx == total - 1);
            grad_store[drain_idx] = 0;
            drain_idx = (drain_idx == total - 1) ? 0 : drain_idx + 1;
            expected_sums.push_back(want);
        end
    endfunction

    function automatic t_in_item load_item(input logic signed [VAL_W-1:0] value,
                                           input logic signed [VAL_W-1:0] grad);
        t_in_item item;
        item.mode        = MODE_LOAD;
        item.input_value = value;
        item.grad_value  = grad;
        return item;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0:       return VAL_TOP;
            1:       return VAL_BOTTOM;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Values come from a narrow range or the extremes half the time so that ties are common.
    function automatic t_in_item make_load();
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] grad;
        case ($urandom_range(3))
            0, 1:    value = $urandom();
            2:       value = (int'($urandom_range(0, 3)) - 1) <<< 16;
            default: value = pick_extreme();
        endcase
        grad = ($urandom_range(3) == 0) ? pick_extreme() : $urandom();
        return load_item(value, grad);
    endfunction

    function automatic t_in_item make_drain();
        t_in_item item;
        item.mode        = MODE_DRAIN;
        item.input_value = $urandom();
        item.grad_value  = $urandom();
        return item;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return CFG_W'($urandom_range(1, 8));
        if (r < 78) return '0;
        if (r < 88) return 7'd64;
        return CFG_W'($urandom_range(65, 127));
    endfunction

    // Offers one item after a random gap and holds it until the transfer.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        track_item(item);
        items_sent++;
    endtask

    task automatic send_loads(input int count);
        repeat (count) send_item(make_load());
    endtask

    task automatic send_drains(input int count);
        repeat (count) send_item(make_drain());
    endtask

    // Brings the block to idle: no item offered, no result owed, no load in flight.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (index == CFG_PLANE_WIDTH) width_reg = value;
        else if (index == CFG_PLANE_HEIGHT) height_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // The receiver stalls at random, or for a counted stretch when one is requested.
    initial begin : receiver
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Every result transfer is compared with the oldest expected sum.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: result with none expected: grad_sum %0d last %0b",
                         $time, out_data.grad_sum, out_data.last_of_plane);
                failures++;
            end else begin
                want = expected_sums.pop_front();
                if (out_data.grad_sum !== want.grad_sum) begin
                    $display("%0t: grad_sum expected %0d actual %0d",
                             $time, want.grad_sum, out_data.grad_sum);
                    failures++;
                end
                if (out_data.last_of_plane !== want.last_of_plane) begin
                    $display("%0t: last_of_plane expected %0b actual %0b",
                             $time, want.last_of_plane, out_data.last_of_plane);
                    failures++;
                end
            end
        end
    end

    task automatic test_reset_sizes();
        // Full-scale values in the first columns of the reset-size plane.
        send_item(load_item(VAL_TOP, VAL_TOP));
        send_item(load_item(VAL_BOTTOM, VAL_BOTTOM));
        send_item(load_item('0, '1));
        send_drains(3);
        // Shrinking the plane leaves both positions outside it, so both restart.
        settle_block();
        write_reg(CFG_PLANE_WIDTH, 7'd1);
        write_reg(CFG_PLANE_HEIGHT, 7'd2);
        send_item(load_item(32'sh000A_0000, 32'sh0001_0000));
        send_item(load_item(32'sh0003_0000, 32'sh0002_0000));
        send_drains(2);
    endtask

    task automatic test_ties_and_size_limits();
        // A zero width acts as one column; the tie on row 1 keeps row 0.
        settle_block();
        write_reg(CFG_PLANE_WIDTH, '0);
        write_reg(CFG_PLANE_HEIGHT, 7'd3);
        send_item(load_item(32'sh0005_0000, 32'sh0000_1000));
        send_item(load_item(32'sh0005_0000, 32'sh0000_2000));
        send_item(load_item(32'sh0007_0000, -32'sh0000_4000));
        send_drains(3);
        // An oversized width acts as the maximum; the spare index is ignored.
        settle_block();
        write_reg(CFG_PLANE_WIDTH, '1);
        write_reg(CFG_PLANE_HEIGHT, '0);
        write_reg(CFG_UNUSED_INDEX, '1);
        send_loads(2);
        send_drains(2);
    endtask

    task automatic test_saturation();
        t_in_item item;
        // On a single-pixel plane every gradient lands in the same entry.
        settle_block();
        write_reg(CFG_PLANE_WIDTH, '0);
        write_reg(CFG_PLANE_HEIGHT, '0);
        repeat (SAT_LOADS) begin
            item = make_load();
            item.grad_value = VAL_TOP;
            send_item(item);
        end
        send_drains(1);
        repeat (SAT_LOADS) begin
            item = make_load();
            item.grad_value = VAL_BOTTOM;
            send_item(item);
        end
        send_drains(1);
    endtask

    task automatic test_backpressure();
        settle_block();
        write_reg(CFG_PLANE_WIDTH, 7'd4);
        write_reg(CFG_PLANE_HEIGHT, 7'd4);
        send_loads(16);
        // The receiver holds off while drains keep coming, so the input stalls.
        hold_cycles = 300;
        send_drains(16);
        // The sender withdraws and waits for every owed result before going on.
        settle_block();
        send_loads(16);
        send_drains(16);
    endtask

    // Mostly whole planes loaded then drained, with mixed and partial runs between.
    task automatic run_random_phase(input int send_pct, input int recv_pct);
        int               start;
        int               w;
        int               h;
        int               total;
        int               pos;
        int               kind;
        logic [CFG_W-1:0] new_w;
        logic [CFG_W-1:0] new_h;
        set_idling(send_pct, recv_pct);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            settle_block();
            if ($urandom_range(99) < 35) begin
                new_w = pick_size();
                new_h = pick_size();
                if (eff_size(new_w, MAX_W) * eff_size(new_h, MAX_H) > MAX_JOB_AREA) begin
                    if ($urandom_range(1)) new_w = CFG_W'($urandom_range(0, 2));
                    else new_h = CFG_W'($urandom_range(0, 2));
                end
                // Widening below row 0 would reach columns with no maximum yet.
                if (load_row != 0 && eff_size(new_w, MAX_W) > eff_size(width_reg, MAX_W))
                    new_w = width_reg;
                write_reg(CFG_PLANE_WIDTH, new_w);
                write_reg(CFG_PLANE_HEIGHT, new_h);
            end
            w     = eff_size(width_reg, MAX_W);
            h     = eff_size(height_reg, MAX_H);
            total = w * h;
            kind  = $urandom_range(99);
            if (kind < 70) begin
                pos = (load_row < h && load_col < w) ? load_row * w + load_col : 0;
                send_loads(total - pos);
                send_drains(total - ((drain_idx < total) ? drain_idx : 0));
            end else if (kind < 85) begin
                repeat ($urandom_range(4, 24))
                    send_item($urandom_range(1) ? make_load() : make_drain());
            end else begin
                send_loads($urandom_range(1, total));
                send_drains($urandom_range(0, total));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0);
        run_random_phase(65, 0);
        run_random_phase(0, 65);
        run_random_phase(38, 38);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_idling(0, 0);
        test_reset_sizes();
        test_ties_and_size_limits();
        test_saturation();
        test_backpressure();
        test_random_traffic();
        settle_block();
        if (failures == 0) begin
            $display("** directional_max_pool_gradient: PASSED **");
        end else begin
            $display("** directional_max_pool_gradient: FAILED **");
        end
        $finish;
    end

endmodule

@@ directional_max_pool_gradient.f @@
hdl/dmpg_pkg.sv
hdl/dmpg_ram.sv
hdl/directional_max_pool_gradient.sv
sim/testbench.sv
